FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`endif

FILE: design/tbp_pkg.sv
// ----------------------------------------------------------------------------
// Tournament predictor package
// Shared command type, counter reset values and counter update function.
// ----------------------------------------------------------------------------
package tbp_pkg;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;   // write reset values at the clear index
		logic load;    // capture a branch and read histories and global tables
		logic lookup;  // read the local counter selected by the local history
		logic commit;  // produce the prediction and write back all updates
	} tbp_cmd_t;

	localparam logic [1:0] CTR_WEAK_NT      = 2'd1;
	localparam logic [1:0] CHOICE_WEAK_LOCAL = 2'd1;

	function automatic logic [1:0] sat_toward(input logic [1:0] ctr, input logic up);
		logic [1:0] res;
		if (up) begin
			res = (ctr == 2'd3) ? 2'd3 : ctr + 2'd1;
		end else begin
			res = (ctr == 2'd0) ? 2'd0 : ctr - 2'd1;
		end
		return res;
	endfunction

endpackage

FILE: design/tbp_ctrl.sv
// ----------------------------------------------------------------------------
// Tournament predictor controller
// Sequences the clearing pass, the two table read steps and the commit,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module tbp_ctrl #(
	parameter int CLR_W = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tbp_pkg::tbp_cmd_t    cmd,
	output logic [CLR_W-1:0]     clr_idx
);
	import tbp_pkg::*;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_HIST, S_CTR} state_t;

	state_t            state_q;
	logic [CLR_W-1:0]  clr_q;
	logic              out_valid_q;
	logic              finish;
	logic              accept;

	// The result can be committed once the output register is free or draining.
	assign finish   = (state_q == S_CTR) && (!out_valid_q || !out_stall);
	assign in_stall = !((state_q == S_IDLE) || finish);
	assign accept   = in_valid && !in_stall;

	assign cmd.clear  = (state_q == S_CLEAR);
	assign cmd.load   = accept;
	assign cmd.lookup = (state_q == S_HIST);
	assign cmd.commit = finish;

	assign clr_idx   = clr_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HIST;
					end
				end
				S_HIST: begin
					state_q <= S_CTR;
				end
				S_CTR: begin
					if (finish) begin
						state_q <= accept ? S_HIST : S_IDLE;
					end
				end
			endcase

			priority if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

endmodule

FILE: design/tbp_dpath.sv
// ----------------------------------------------------------------------------
// Tournament predictor datapath
// Holds the history and counter tables, the global history and the
// prediction register, and computes the training updates.
// ----------------------------------------------------------------------------
module tbp_dpath #(
	parameter int LOCAL_HISTORY_BITS  = 10,
	parameter int GLOBAL_HISTORY_BITS = 12,
	parameter int PC_INDEX_BITS       = 10,
	parameter int CLR_W               = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbp_pkg::tbp_cmd_t    cmd,
	input  logic [CLR_W-1:0]     clr_idx,
	input  logic [31:0]          pc,
	input  logic                 outcome,
	output logic                 prediction
);
	import tbp_pkg::*;

	localparam int L = LOCAL_HISTORY_BITS;
	localparam int G = GLOBAL_HISTORY_BITS;
	localparam int P = PC_INDEX_BITS;

	logic [L-1:0] lht_mem  [2**P];
	logic [1:0]   lctr_mem [2**L];
	logic [1:0]   gctr_mem [2**G];
	logic [1:0]   cctr_mem [2**G];

	logic [P-1:0] pidx_s1;
	logic         taken_s1;
	logic [G-1:0] ghist_q;
	logic [L-1:0] lhist_q;
	logic [1:0]   lctr_q;
	logic [1:0]   gctr_q;
	logic [1:0]   cctr_q;
	logic         prediction_q;

	logic [P-1:0] pc_idx;
	logic [L-1:0] lhist_new;
	logic [G-1:0] ghist_new;
	logic [G-1:0] g_rd_addr;
	logic         lpred;
	logic         gpred;
	logic         pred;
	logic [1:0]   lctr_new;
	logic [1:0]   gctr_new;
	logic [1:0]   cctr_new;

	logic         lht_we;
	logic [P-1:0] lht_wa;
	logic [L-1:0] lht_wd;
	logic         lctr_we;
	logic [L-1:0] lctr_wa;
	logic [1:0]   lctr_wd;
	logic         g_we;
	logic [G-1:0] g_wa;
	logic [1:0]   gctr_wd;
	logic [1:0]   cctr_wd;

	assign pc_idx = pc[P-1:0];

	assign lhist_new = L'({lhist_q, taken_s1});
	assign ghist_new = G'({ghist_q, taken_s1});

	assign lpred = lctr_q[1];
	assign gpred = gctr_q[1];
	assign pred  = cctr_q[1] ? gpred : lpred;

	assign lctr_new = sat_toward(lctr_q, taken_s1);
	assign gctr_new = sat_toward(gctr_q, taken_s1);
	assign cctr_new = (lpred != gpred) ? sat_toward(cctr_q, gpred == taken_s1) : cctr_q;

	// A branch loaded at the commit edge reads the global tables at the new history.
	assign g_rd_addr = cmd.commit ? ghist_new : ghist_q;

	assign lht_we  = cmd.clear || cmd.commit;
	assign lht_wa  = cmd.clear ? clr_idx[P-1:0] : pidx_s1;
	assign lht_wd  = cmd.clear ? '0 : lhist_new;
	assign lctr_we = cmd.clear || cmd.commit;
	assign lctr_wa = cmd.clear ? clr_idx[L-1:0] : lhist_q;
	assign lctr_wd = cmd.clear ? CTR_WEAK_NT : lctr_new;
	assign g_we    = cmd.clear || cmd.commit;
	assign g_wa    = cmd.clear ? clr_idx[G-1:0] : ghist_q;
	assign gctr_wd = cmd.clear ? CTR_WEAK_NT : gctr_new;
	assign cctr_wd = cmd.clear ? CHOICE_WEAK_LOCAL : cctr_new;

	// Reads that meet a write to the same entry see the new value.
	always_ff @(posedge clk) begin
		if (lht_we) begin
			lht_mem[lht_wa] <= lht_wd;
		end
		if (cmd.load) begin
			lhist_q <= (cmd.commit && (pidx_s1 == pc_idx)) ? lhist_new : lht_mem[pc_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (lctr_we) begin
			lctr_mem[lctr_wa] <= lctr_wd;
		end
		if (cmd.lookup) begin
			lctr_q <= lctr_mem[lhist_q];
		end
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			gctr_mem[g_wa] <= gctr_wd;
		end
		if (cmd.load) begin
			gctr_q <= (cmd.commit && (g_rd_addr == ghist_q)) ? gctr_new : gctr_mem[g_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			cctr_mem[g_wa] <= cctr_wd;
		end
		if (cmd.load) begin
			cctr_q <= (cmd.commit && (g_rd_addr == ghist_q)) ? cctr_new : cctr_mem[g_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pidx_s1  <= pc_idx;
			taken_s1 <= outcome;
		end
		if (cmd.commit) begin
			prediction_q <= pred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghist_q <= '0;
		end else if (cmd.commit) begin
			ghist_q <= ghist_new;
		end
	end

	assign prediction = prediction_q;

endmodule

FILE: design/tournament_branch_predictor.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Local and global two-bit counter predictors with a choice table; each
// resolved branch returns the prediction made before training on it.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// input     in_valid / in_stall    pc[31:0], outcome
// output    out_valid / out_stall  prediction
//
// An accepted branch reads the local history and the global tables, the
// lookup state reads the local counter that the history selects and the
// commit state commits all updates. A new branch is taken at the commit edge.
// After reset a clearing pass over 2**max(PC_INDEX_BITS, LOCAL_HISTORY_BITS,
// GLOBAL_HISTORY_BITS) indices (4096 by default) writes every table.
// A stalled output holds the commit until the output register drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tournament_branch_predictor #(
	parameter int LOCAL_HISTORY_BITS  = 10,
	parameter int GLOBAL_HISTORY_BITS = 12,
	parameter int PC_INDEX_BITS       = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pc,
	input  logic        outcome,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        prediction
);
	import tbp_pkg::*;

	localparam int CLR_W = (PC_INDEX_BITS > LOCAL_HISTORY_BITS)
		? ((PC_INDEX_BITS > GLOBAL_HISTORY_BITS) ? PC_INDEX_BITS : GLOBAL_HISTORY_BITS)
		: ((LOCAL_HISTORY_BITS > GLOBAL_HISTORY_BITS) ? LOCAL_HISTORY_BITS
			: GLOBAL_HISTORY_BITS);

	tbp_cmd_t          cmd;
	logic [CLR_W-1:0]  clr_idx;

	tbp_ctrl #(
		.CLR_W(CLR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.clr_idx   (clr_idx)
	);

	tbp_dpath #(
		.LOCAL_HISTORY_BITS  (LOCAL_HISTORY_BITS),
		.GLOBAL_HISTORY_BITS (GLOBAL_HISTORY_BITS),
		.PC_INDEX_BITS       (PC_INDEX_BITS),
		.CLR_W               (CLR_W)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.clr_idx    (clr_idx),
		.pc         (pc),
		.outcome    (outcome),
		.prediction (prediction)
	);

	// An accepted transaction occupies the block for its read step.
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	// Clearing, lookup and commit never overlap.
	`ASSERT_ALWAYS(a_cmd_excl, clk, arst_n, $onehot0({cmd.clear, cmd.lookup, cmd.commit}))
	// No transaction moves while the tables are being cleared.
	`ASSERT_IMPL(a_clear_quiet, clk, arst_n, cmd.clear, in_stall && !out_valid)

endmodule
